FILE: hdl/mrrts_pkg.sv
// ----------------------------------------------------------------------------
// mrrts_pkg
// Shared types and constants of the multilevel round-robin task scheduler:
// operation codes, status codes, task slot states and the control states.
// ----------------------------------------------------------------------------
package mrrts_pkg;

    // Default sizes
    localparam int NUM_TASKS_DEF  = 64;
    localparam int LIST_DEPTH_DEF = 64;
    localparam int NUM_LEVELS_DEF = 8;

    // Request operations
    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_RUN   = 2'd1,
        OP_SLEEP = 2'd2,
        OP_TICK  = 2'd3
    } op_t;

    // Result status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NO_SLOT    = 2'd1;
    localparam logic [1:0] ST_LEVEL_FULL = 2'd2;

    // Task slot states
    localparam logic [1:0] TS_FREE   = 2'd0;
    localparam logic [1:0] TS_HELD   = 2'd1;
    localparam logic [1:0] TS_LISTED = 2'd2;

    // Sequencer states
    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_CUR_RD,
        S_CUR_WT,
        S_DISPATCH,
        S_AL_RD,
        S_AL_CK,
        S_RUN_CK,
        S_RUN_CNT,
        S_SLP_CK,
        S_TK_CK,
        S_TK_CNT,
        S_TK_WRAP,
        S_TO_RD,
        S_TO_CK,
        S_TO_END,
        S_APPEND,
        S_SCAN,
        S_OUT
    } state_t;

endpackage

FILE: hdl/multilevel_round_robin_task_scheduler.sv
// ----------------------------------------------------------------------------
// multilevel_round_robin_task_scheduler
// Priority-level task scheduler with one rotating run list per level. Task
// slots live in one memory, all run lists in a second; a sequencer reads,
// modifies and writes them back one step at a time.
// ----------------------------------------------------------------------------
//
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------------------
//  request  | start & !busy          | op, task_id, new_level, keep_level,
//           |                        | new_priority
//  result   | done (one cycle)       | current_task, current_valid, do_switch,
//           |                        | timer_reload, alloc_task, status
//
//  A request runs through its sequence of states plus its walks: allocate
//  checks the slots one at a time, a removal from a run list walks the list
//  entry by entry (search and compaction share one pass over the list memory
//  port), and a level rescan checks one level per cycle.
//  After reset a clearing pass over all NUM_TASKS slots runs with busy high.
//  The next request is taken in the cycle its predecessor's result shows.
//  The result receiver cannot stall; done marks each result for one cycle.

module multilevel_round_robin_task_scheduler #(
    parameter int NUM_TASKS  = mrrts_pkg::NUM_TASKS_DEF,
    parameter int LIST_DEPTH = mrrts_pkg::LIST_DEPTH_DEF,
    parameter int NUM_LEVELS = mrrts_pkg::NUM_LEVELS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] op,
    input  logic [5:0] task_id,
    input  logic [2:0] new_level,
    input  logic       keep_level,
    input  logic [7:0] new_priority,
    output logic       done,
    output logic [5:0] current_task,
    output logic       current_valid,
    output logic       do_switch,
    output logic [7:0] timer_reload,
    output logic [5:0] alloc_task,
    output logic [1:0] status
);

    localparam int TW  = $clog2(NUM_TASKS);
    localparam int IW  = $clog2(LIST_DEPTH);
    localparam int CW  = $clog2(LIST_DEPTH + 1);
    localparam int LVW = $clog2(NUM_LEVELS);
    localparam int AW  = $clog2(NUM_LEVELS + 1);
    localparam int EW  = 2 + LVW + 8;
    localparam int LMD = NUM_LEVELS << IW;

    // Memories: task table {state, level, slice} and run list entries
    logic [EW-1:0] tmem [NUM_TASKS];
    logic [TW-1:0] lmem [LMD];
    logic [EW-1:0] tm_rd;
    logic [TW-1:0] lm_rd;
    logic [TW-1:0] tm_ra, tm_wa;
    logic          tm_we;
    logic [EW-1:0] tm_wd;
    logic [LVW+IW-1:0] lm_ra, lm_wa;
    logic          lm_we;
    logic [TW-1:0] lm_wd;

    // Per-level count and pointer, accessed at lx_reg only
    logic [CW-1:0] cnt_reg [NUM_LEVELS];
    logic [CW-1:0] ptr_reg [NUM_LEVELS];
    logic          cnt_we, ptr_we;
    logic [CW-1:0] cnt_next, ptr_next;
    logic [CW-1:0] cnt_cur, ptr_cur;

    mrrts_pkg::state_t state_reg, state_next;
    mrrts_pkg::op_t    op_reg, op_next;
    logic          phase_reg, phase_next;
    logic          had_reg, had_next;
    logic [TW-1:0] bef_reg, bef_next;
    logic [EW-1:0] ent_reg, ent_next;
    logic [LVW-1:0] tgt_reg, tgt_next;
    logic [LVW-1:0] lx_reg, lx_next;
    logic [CW-1:0] ix_reg, ix_next;
    logic          fnd_reg, fnd_next;
    logic [CW-1:0] fidx_reg, fidx_next;
    logic [TW-1:0] tk_reg, tk_next;
    logic [TW-1:0] scan_reg, scan_next;
    logic [AW-1:0] act_reg, act_next;
    logic          rchk_reg, rchk_next;
    logic [TW-1:0] t_reg, t_next;
    logic          tok_reg, tok_next;
    logic [LVW-1:0] lvin_reg, lvin_next;
    logic          keep_reg, keep_next;
    logic [7:0]    sl_reg, sl_next;
    logic          done_reg, done_next;
    logic [TW-1:0] curt_reg, curt_next;
    logic          curv_reg, curv_next;
    logic          sw_reg, sw_next;
    logic [7:0]    rl_reg, rl_next;
    logic [TW-1:0] al_reg, al_next;
    logic [1:0]    st_reg, st_next;

    // Field views and width conversions
    logic [1:0]     tm_st, ent_st;
    logic [LVW-1:0] tm_lv, ent_lv, run_tgt;
    logic [7:0]     tm_sl, ent_sl, new_sl;
    logic [TW+5:0]  tid_x, curt_x, al_x;
    logic [LVW+2:0] nl_x;
    logic [LVW-1:0] nl_sat;
    logic           cur_ok;
    logic [CW-1:0]  to_n, to_p0, to_p;

    assign tm_st  = tm_rd[EW-1 -: 2];
    assign tm_lv  = tm_rd[8 +: LVW];
    assign tm_sl  = tm_rd[7:0];
    assign ent_st = ent_reg[EW-1 -: 2];
    assign ent_lv = ent_reg[8 +: LVW];
    assign ent_sl = ent_reg[7:0];
    assign run_tgt = keep_reg ? tm_lv : lvin_reg;
    assign new_sl = (op_reg == mrrts_pkg::OP_RUN && sl_reg != 8'd0) ? sl_reg : ent_sl;

    assign tid_x  = {{TW{1'b0}}, task_id};
    assign nl_x   = {{LVW{1'b0}}, new_level};
    assign nl_sat = (32'(new_level) >= NUM_LEVELS) ? LVW'(NUM_LEVELS - 1) : nl_x[LVW-1:0];

    assign cnt_cur = cnt_reg[lx_reg];
    assign ptr_cur = ptr_reg[lx_reg];
    assign cur_ok  = (32'(act_reg) < NUM_LEVELS) && (cnt_cur != '0) && (ptr_cur < cnt_cur);

    // Count and pointer after a successful take-out
    assign to_n  = cnt_cur - 1'b1;
    assign to_p0 = (fidx_reg < ptr_cur) ? ptr_cur - 1'b1 : ptr_cur;
    assign to_p  = (to_p0 >= to_n) ? '0 : to_p0;

    // Task table memory
    always_ff @(posedge clk)
    begin
        if (tm_we)
        begin
            tmem[tm_wa] <= tm_wd;
        end
        tm_rd <= tmem[tm_ra];
    end

    // Run list memory
    always_ff @(posedge clk)
    begin
        if (lm_we)
        begin
            lmem[lm_wa] <= lm_wd;
        end
        lm_rd <= lmem[lm_ra];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mrrts_pkg::S_CLEAR;
            scan_reg  <= '0;
            act_reg   <= AW'(NUM_LEVELS);
            rchk_reg  <= 1'b0;
            done_reg  <= 1'b0;
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                cnt_reg[i] <= '0;
                ptr_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            scan_reg  <= scan_next;
            act_reg   <= act_next;
            rchk_reg  <= rchk_next;
            done_reg  <= done_next;
            if (cnt_we)
            begin
                cnt_reg[lx_reg] <= cnt_next;
            end
            if (ptr_we)
            begin
                ptr_reg[lx_reg] <= ptr_next;
            end
        end
    end

    // Working and result registers
    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        phase_reg <= phase_next;
        had_reg  <= had_next;
        bef_reg  <= bef_next;
        ent_reg  <= ent_next;
        tgt_reg  <= tgt_next;
        lx_reg   <= lx_next;
        ix_reg   <= ix_next;
        fnd_reg  <= fnd_next;
        fidx_reg <= fidx_next;
        tk_reg   <= tk_next;
        t_reg    <= t_next;
        tok_reg  <= tok_next;
        lvin_reg <= lvin_next;
        keep_reg <= keep_next;
        sl_reg   <= sl_next;
        curt_reg <= curt_next;
        curv_reg <= curv_next;
        sw_reg   <= sw_next;
        rl_reg   <= rl_next;
        al_reg   <= al_next;
        st_reg   <= st_next;
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        phase_next = phase_reg;
        had_next   = had_reg;
        bef_next   = bef_reg;
        ent_next   = ent_reg;
        tgt_next   = tgt_reg;
        lx_next    = lx_reg;
        ix_next    = ix_reg;
        fnd_next   = fnd_reg;
        fidx_next  = fidx_reg;
        tk_next    = tk_reg;
        scan_next  = scan_reg;
        act_next   = act_reg;
        rchk_next  = rchk_reg;
        t_next     = t_reg;
        tok_next   = tok_reg;
        lvin_next  = lvin_reg;
        keep_next  = keep_reg;
        sl_next    = sl_reg;
        done_next  = 1'b0;
        curt_next  = curt_reg;
        curv_next  = curv_reg;
        sw_next    = sw_reg;
        rl_next    = rl_reg;
        al_next    = al_reg;
        st_next    = st_reg;
        cnt_we     = 1'b0;
        cnt_next   = cnt_cur;
        ptr_we     = 1'b0;
        ptr_next   = ptr_cur;
        tm_ra      = tk_reg;
        tm_we      = 1'b0;
        tm_wa      = tk_reg;
        tm_wd      = ent_reg;
        lm_ra      = {lx_reg, ix_reg[IW-1:0]};
        lm_we      = 1'b0;
        lm_wa      = {lx_reg, ix_reg[IW-1:0]};
        lm_wd      = tk_reg;

        unique case (state_reg)
            // Clear task table after reset
            mrrts_pkg::S_CLEAR:
            begin
                tm_we = 1'b1;
                tm_wa = scan_reg;
                tm_wd = '0;
                if (scan_reg == TW'(NUM_TASKS - 1))
                begin
                    state_next = mrrts_pkg::S_IDLE;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end

            mrrts_pkg::S_IDLE:
            begin
                if (start)
                begin
                    op_next    = mrrts_pkg::op_t'(op);
                    t_next     = tid_x[TW-1:0];
                    tok_next   = 32'(task_id) < NUM_TASKS;
                    lvin_next  = nl_sat;
                    keep_next  = keep_level;
                    sl_next    = new_priority;
                    al_next    = '0;
                    st_next    = mrrts_pkg::ST_OK;
                    phase_next = 1'b0;
                    lx_next    = act_reg[LVW-1:0];
                    state_next = mrrts_pkg::S_CUR_RD;
                end
            end

            // Look up the current task (before or after the request)
            mrrts_pkg::S_CUR_RD:
            begin
                lm_ra = {lx_reg, ptr_cur[IW-1:0]};
                if (cur_ok)
                begin
                    state_next = mrrts_pkg::S_CUR_WT;
                end
                else if (!phase_reg)
                begin
                    had_next   = 1'b0;
                    state_next = mrrts_pkg::S_DISPATCH;
                end
                else
                begin
                    curt_next  = '0;
                    curv_next  = 1'b0;
                    sw_next    = 1'b0;
                    rl_next    = 8'd0;
                    done_next  = 1'b1;
                    state_next = mrrts_pkg::S_IDLE;
                end
            end

            mrrts_pkg::S_CUR_WT:
            begin
                if (!phase_reg)
                begin
                    had_next   = 1'b1;
                    bef_next   = lm_rd;
                    state_next = mrrts_pkg::S_DISPATCH;
                end
                else
                begin
                    tk_next    = lm_rd;
                    tm_ra      = lm_rd;
                    state_next = mrrts_pkg::S_OUT;
                end
            end

            mrrts_pkg::S_DISPATCH:
            begin
                tk_next = t_reg;
                tm_ra   = t_reg;
                unique case (op_reg)
                    mrrts_pkg::OP_ALLOC:
                    begin
                        scan_next  = '0;
                        state_next = mrrts_pkg::S_AL_RD;
                    end
                    mrrts_pkg::OP_RUN:
                    begin
                        if (tok_reg)
                        begin
                            state_next = mrrts_pkg::S_RUN_CK;
                        end
                        else
                        begin
                            phase_next = 1'b1;
                            state_next = mrrts_pkg::S_CUR_RD;
                        end
                    end
                    mrrts_pkg::OP_SLEEP:
                    begin
                        if (tok_reg)
                        begin
                            state_next = mrrts_pkg::S_SLP_CK;
                        end
                        else
                        begin
                            phase_next = 1'b1;
                            state_next = mrrts_pkg::S_CUR_RD;
                        end
                    end
                    mrrts_pkg::OP_TICK:
                    begin
                        if (had_reg)
                        begin
                            // advance the active level's pointer
                            ptr_we     = 1'b1;
                            ptr_next   = ptr_cur + 1'b1;
                            tk_next    = bef_reg;
                            tm_ra      = bef_reg;
                            state_next = mrrts_pkg::S_TK_CK;
                        end
                        else
                        begin
                            lx_next    = '0;
                            state_next = mrrts_pkg::S_SCAN;
                        end
                    end
                    default:
                    begin
                        state_next = mrrts_pkg::S_IDLE;
                    end
                endcase
            end

            // Allocate: lowest free slot
            mrrts_pkg::S_AL_RD:
            begin
                tm_ra      = scan_reg;
                state_next = mrrts_pkg::S_AL_CK;
            end

            mrrts_pkg::S_AL_CK:
            begin
                if (tm_st == mrrts_pkg::TS_FREE)
                begin
                    tm_we      = 1'b1;
                    tm_wa      = scan_reg;
                    tm_wd      = {mrrts_pkg::TS_HELD, tm_lv, tm_sl};
                    al_next    = scan_reg;
                    phase_next = 1'b1;
                    lx_next    = act_reg[LVW-1:0];
                    state_next = mrrts_pkg::S_CUR_RD;
                end
                else if (scan_reg == TW'(NUM_TASKS - 1))
                begin
                    st_next    = mrrts_pkg::ST_NO_SLOT;
                    phase_next = 1'b1;
                    lx_next    = act_reg[LVW-1:0];
                    state_next = mrrts_pkg::S_CUR_RD;
                end
                else
                begin
                    scan_next  = scan_reg + 1'b1;
                    state_next = mrrts_pkg::S_AL_RD;
                end
            end

            // Run or wake
            mrrts_pkg::S_RUN_CK:
            begin
                ent_next = tm_rd;
                if (tm_st == mrrts_pkg::TS_FREE)
                begin
                    phase_next = 1'b1;
                    lx_next    = act_reg[LVW-1:0];
                    state_next = mrrts_pkg::S_CUR_RD;
                end
                else if (tm_st == mrrts_pkg::TS_LISTED && tm_lv == run_tgt)
                begin
                    tm_we      = 1'b1;
                    tm_wd      = {tm_st, tm_lv, (sl_reg != 8'd0) ? sl_reg : tm_sl};
                    rchk_next  = 1'b1;
                    phase_next = 1'b1;
                    lx_next    = act_reg[LVW-1:0];
                    state_next = mrrts_pkg::S_CUR_RD;
                end
                else
                begin
                    tgt_next   = run_tgt;
                    lx_next    = run_tgt;
                    state_next = mrrts_pkg::S_RUN_CNT;
                end
            end

            mrrts_pkg::S_RUN_CNT:
            begin
                if (cnt_cur >= CW'(LIST_DEPTH))
                begin
                    st_next    = mrrts_pkg::ST_LEVEL_FULL;
                    phase_next = 1'b1;
                    lx_next    = act_reg[LVW-1:0];
                    state_next = mrrts_pkg::S_CUR_RD;
                end
                else if (ent_st == mrrts_pkg::TS_LISTED)
                begin
                    lx_next    = ent_lv;
                    ix_next    = '0;
                    fnd_next   = 1'b0;
                    state_next = mrrts_pkg::S_TO_RD;
                end
                else
                begin
                    state_next = mrrts_pkg::S_APPEND;
                end
            end

            // Sleep
            mrrts_pkg::S_SLP_CK:
            begin
                ent_next = tm_rd;
                if (tm_st == mrrts_pkg::TS_LISTED)
                begin
                    lx_next    = tm_lv;
                    ix_next    = '0;
                    fnd_next   = 1'b0;
                    state_next = mrrts_pkg::S_TO_RD;
                end
                else
                begin
                    phase_next = 1'b1;
                    lx_next    = act_reg[LVW-1:0];
                    state_next = mrrts_pkg::S_CUR_RD;
                end
            end

            // Tick: demotion check on the task that was running
            mrrts_pkg::S_TK_CK:
            begin
                ent_next = tm_rd;
                if (32'(tm_lv) < NUM_LEVELS - 2 && tm_lv == lx_reg)
                begin
                    tgt_next   = lx_reg + 1'b1;
                    lx_next    = lx_reg + 1'b1;
                    state_next = mrrts_pkg::S_TK_CNT;
                end
                else
                begin
                    state_next = mrrts_pkg::S_TK_WRAP;
                end
            end

            mrrts_pkg::S_TK_CNT:
            begin
                lx_next = act_reg[LVW-1:0];
                ix_next = '0;
                fnd_next = 1'b0;
                if (cnt_cur < CW'(LIST_DEPTH))
                begin
                    state_next = mrrts_pkg::S_TO_RD;
                end
                else
                begin
                    state_next = mrrts_pkg::S_TK_WRAP;
                end
            end

            mrrts_pkg::S_TK_WRAP:
            begin
                if (ptr_cur >= cnt_cur)
                begin
                    ptr_we   = 1'b1;
                    ptr_next = '0;
                end
                if (rchk_reg)
                begin
                    lx_next    = '0;
                    state_next = mrrts_pkg::S_SCAN;
                end
                else
                begin
                    phase_next = 1'b1;
                    lx_next    = act_reg[LVW-1:0];
                    state_next = mrrts_pkg::S_CUR_RD;
                end
            end

            // Take-out: search and compact in one pass
            mrrts_pkg::S_TO_RD:
            begin
                if (ix_reg == cnt_cur)
                begin
                    state_next = mrrts_pkg::S_TO_END;
                end
                else
                begin
                    state_next = mrrts_pkg::S_TO_CK;
                end
            end

            mrrts_pkg::S_TO_CK:
            begin
                if (fnd_reg)
                begin
                    lm_we = 1'b1;
                    lm_wa = {lx_reg, IW'(ix_reg - 1'b1)};
                    lm_wd = lm_rd;
                end
                else if (lm_rd == tk_reg)
                begin
                    fnd_next  = 1'b1;
                    fidx_next = ix_reg;
                end
                ix_next    = ix_reg + 1'b1;
                state_next = mrrts_pkg::S_TO_RD;
            end

            mrrts_pkg::S_TO_END:
            begin
                if (fnd_reg)
                begin
                    cnt_we   = 1'b1;
                    cnt_next = to_n;
                    ptr_we   = 1'b1;
                    ptr_next = to_p;
                end
                if (op_reg == mrrts_pkg::OP_SLEEP)
                begin
                    if (fnd_reg)
                    begin
                        tm_we = 1'b1;
                        tm_wd = {mrrts_pkg::TS_HELD, ent_lv, ent_sl};
                    end
                    if (had_reg && bef_reg == tk_reg)
                    begin
                        lx_next    = '0;
                        state_next = mrrts_pkg::S_SCAN;
                    end
                    else
                    begin
                        phase_next = 1'b1;
                        lx_next    = act_reg[LVW-1:0];
                        state_next = mrrts_pkg::S_CUR_RD;
                    end
                end
                else
                begin
                    lx_next    = tgt_reg;
                    state_next = mrrts_pkg::S_APPEND;
                end
            end

            // Append at the tail of level lx_reg
            mrrts_pkg::S_APPEND:
            begin
                lm_we     = 1'b1;
                lm_wa     = {lx_reg, cnt_cur[IW-1:0]};
                lm_wd     = tk_reg;
                cnt_we    = 1'b1;
                cnt_next  = cnt_cur + 1'b1;
                tm_we     = 1'b1;
                tm_wd     = {mrrts_pkg::TS_LISTED, lx_reg, new_sl};
                rchk_next = 1'b1;
                if (op_reg == mrrts_pkg::OP_TICK)
                begin
                    lx_next    = '0;
                    state_next = mrrts_pkg::S_SCAN;
                end
                else
                begin
                    phase_next = 1'b1;
                    lx_next    = act_reg[LVW-1:0];
                    state_next = mrrts_pkg::S_CUR_RD;
                end
            end

            // Rescan: first non-empty level from level 0 upward, one level a cycle
            mrrts_pkg::S_SCAN:
            begin
                if (cnt_cur != '0)
                begin
                    act_next   = AW'(lx_reg);
                    rchk_next  = 1'b0;
                    phase_next = 1'b1;
                    state_next = mrrts_pkg::S_CUR_RD;
                end
                else if (lx_reg == LVW'(NUM_LEVELS - 1))
                begin
                    act_next   = AW'(NUM_LEVELS);
                    rchk_next  = 1'b0;
                    phase_next = 1'b1;
                    state_next = mrrts_pkg::S_CUR_RD;
                end
                else
                begin
                    lx_next = lx_reg + 1'b1;
                end
            end

            // Result with the new current task
            mrrts_pkg::S_OUT:
            begin
                curt_next  = tk_reg;
                curv_next  = 1'b1;
                sw_next    = !had_reg || (bef_reg != tk_reg);
                rl_next    = tm_sl;
                done_next  = 1'b1;
                state_next = mrrts_pkg::S_IDLE;
            end

            default:
            begin
                state_next = mrrts_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs
    assign curt_x = {6'd0, curt_reg};
    assign al_x   = {6'd0, al_reg};

    assign busy          = (state_reg != mrrts_pkg::S_IDLE);
    assign done          = done_reg;
    assign current_task  = curt_x[5:0];
    assign current_valid = curv_reg;
    assign do_switch     = sw_reg;
    assign timer_reload  = rl_reg;
    assign alloc_task    = al_x[5:0];
    assign status        = st_reg;

`ifndef NO_ASSERTIONS
    // A result shows only once the sequencer is back to idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // An accepted request occupies the sequencer next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but sequencer idle");

    // No current task means empty result fields
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !current_valid) |-> (current_task == 6'd0 && timer_reload == 8'd0
            && !do_switch))
        else $error("empty result carries data");

    // Active level never exceeds the none marker
    a_act_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(act_reg) <= NUM_LEVELS)
        else $error("active level out of range");
`endif

endmodule
